[src/clock_page_replacement_macros.svh]
// ----------------------------------------------------------------------------
// Clock page replacement assertion macros
// Shared concurrent assertion forms, compiled out under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, checked every edge out of reset
`define CPR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("clock page replacement check failed");
// antecedent implies consequent in the same cycle
`define CPR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clock page replacement check failed");
`else
`define CPR_ASSERT(lbl, prop)
`define CPR_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[src/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// Clock page replacement package
// Widths, defaults, FSM states and the cell control word.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	localparam int CFG_W        = 5;
	localparam int PAGE_PORT_W  = 16;
	localparam int FRAME_PORT_W = 4;
	localparam int FAULT_W      = 32;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_FINISH
	} cpr_state_t;

	// per-cell control: shift this cycle, and take the feedback word
	typedef struct packed {
		logic en;
		logic wrap;
	} cell_ctrl_t;

endpackage

[src/cpr_cell.sv]
// ----------------------------------------------------------------------------
// Clock page replacement frame cell
// Holds one frame (page, valid, use) and loads from its neighbor or the
// ring feedback when the ring shifts.
// ----------------------------------------------------------------------------
module cpr_cell
	import cpr_pkg::*;
#(
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [PAGE_BITS-1:0] nb_page,
	input  logic                 nb_valid,
	input  logic                 nb_use,
	input  logic [PAGE_BITS-1:0] fb_page,
	input  logic                 fb_valid,
	input  logic                 fb_use,
	output logic [PAGE_BITS-1:0] page,
	output logic                 valid,
	output logic                 use_flag
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 use_q;

	// page store needs no reset, valid gates it
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			page_q <= ctrl.wrap ? fb_page : nb_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			use_q   <= 1'b0;
		end else if (ctrl.en) begin
			valid_q <= ctrl.wrap ? fb_valid : nb_valid;
			use_q   <= ctrl.wrap ? fb_use : nb_use;
		end
	end

	assign page     = page_q;
	assign valid    = valid_q;
	assign use_flag = use_q;

endmodule

[src/clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// Clock page replacement
// Second-chance page replacement over a rotating ring of frame cells.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | page_number
//  out      | out_valid / out_stall| hit, frame_index, evicted_valid,
//           |                      | evicted_page, fault_total
//  cfg      | cfg_wr_en            | cfg_wr_data (frames_in_use)
//
//  n = effective frame count (frames_in_use clamped to 1..FRAMES).
//  A hit result is registered after the SEARCH pass and FINISH, a miss after
//  an extra pass in UPDATE; the next word is taken once the FSM is back in IDLE.
//  The ring sets the pace: cells rotate one position a cycle while SEARCH or
//  UPDATE shifts them, and only the head cell (cell 0) is examined, so each
//  pass brings every one of the n frames past the head.
//  Reset clears valid and use bits, hand, fault count; frames_in_use = 16.
//  A word waiting on out does not block accepting the next input word; a
//  finished word waits in FINISH until the output register frees up.
//
// ----------------------------------------------------------------------------
module clock_page_replacement
	import cpr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic [CFG_W-1:0]        cfg_wr_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PAGE_PORT_W-1:0]  page_number,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic [FRAME_PORT_W-1:0] frame_index,
	output logic                    evicted_valid,
	output logic [PAGE_PORT_W-1:0]  evicted_page,
	output logic [FAULT_W-1:0]      fault_total
);

	`include "clock_page_replacement_macros.svh"

	// frame index width, frame count width, port extension widths
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);
	localparam int FX = (FW > FRAME_PORT_W) ? FW : FRAME_PORT_W;
	localparam int PX = (PAGE_BITS > PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;

	// ------------------------------------------------------------------
	// configuration and effective frame count
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] frames_cfg_q;
	logic [CW-1:0]    n_eff;
	logic [FW-1:0]    last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= FRAMES_IN_USE_RST;
		end else if (cfg_wr_en) begin
			frames_cfg_q <= cfg_wr_data;
		end
	end

	// zero acts as one, anything past FRAMES acts as FRAMES
	always_comb begin
		if (32'(frames_cfg_q) > FRAMES) begin
			n_eff = CW'(FRAMES);
		end else if (frames_cfg_q == '0) begin
			n_eff = CW'(1);
		end else begin
			n_eff = CW'(frames_cfg_q);
		end
	end

	assign last_idx = FW'(n_eff - CW'(1));

	// ------------------------------------------------------------------
	// FSM
	// ------------------------------------------------------------------
	cpr_state_t state_q, state_nxt;
	logic       out_free;
	logic       shift;
	logic       load_out;
	logic       at_last;
	logic       hit_now;

	logic [FW-1:0] idx_q;

	assign out_free = !out_valid || !out_stall;
	assign at_last  = (idx_q == last_idx);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (at_last) begin
					state_nxt = hit_now ? ST_FINISH : ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (at_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		shift    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SEARCH: shift    = 1'b1;
			ST_UPDATE: shift    = 1'b1;
			ST_FINISH: load_out = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------
	// cell ring: cell i takes cell i+1, cell n-1 takes the head feedback
	// ------------------------------------------------------------------
	logic [PAGE_BITS-1:0] c_page  [FRAMES];
	logic                 c_valid [FRAMES];
	logic                 c_use   [FRAMES];
	cell_ctrl_t           c_ctrl  [FRAMES];

	logic [PAGE_BITS-1:0] fb_page;
	logic                 fb_valid;
	logic                 fb_use;

	logic [PAGE_BITS-1:0] head_page;
	logic                 head_valid;
	logic                 head_use;

	assign head_page  = c_page[0];
	assign head_valid = c_valid[0];
	assign head_use   = c_use[0];

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		assign c_ctrl[i].en   = shift && (FW'(i) <= last_idx);
		assign c_ctrl[i].wrap = (FW'(i) == last_idx);

		if (i < FRAMES - 1) begin : g_mid
			cpr_cell #(
				.PAGE_BITS(PAGE_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (c_ctrl[i]),
				.nb_page  (c_page[i+1]),
				.nb_valid (c_valid[i+1]),
				.nb_use   (c_use[i+1]),
				.fb_page  (fb_page),
				.fb_valid (fb_valid),
				.fb_use   (fb_use),
				.page     (c_page[i]),
				.valid    (c_valid[i]),
				.use_flag (c_use[i])
			);
		end else begin : g_end
			// top cell always wraps when it shifts
			cpr_cell #(
				.PAGE_BITS(PAGE_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (c_ctrl[i]),
				.nb_page  (fb_page),
				.nb_valid (fb_valid),
				.nb_use   (fb_use),
				.fb_page  (fb_page),
				.fb_valid (fb_valid),
				.fb_use   (fb_use),
				.page     (c_page[i]),
				.valid    (c_valid[i]),
				.use_flag (c_use[i])
			);
		end
	end

	// ------------------------------------------------------------------
	// per-item datapath
	// ------------------------------------------------------------------
	logic [PX-1:0]        page_ext;
	logic [PAGE_BITS-1:0] page_q;
	logic [FW-1:0]        hand_q;
	logic                 hit_q;
	logic [FW-1:0]        hit_frame_q;
	logic                 cand_hi_q;     // clear use bit seen at or past hand
	logic [FW-1:0]        cand_hi_idx_q;
	logic                 cand_lo_q;     // clear use bit seen anywhere
	logic [FW-1:0]        cand_lo_idx_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [FW-1:0]        ev_frame_q;    // victim frame, hand moves on after it
	logic [FAULT_W-1:0]   fault_q;

	logic                 match;
	logic [FW-1:0]        chosen;
	logic                 all_set;
	logic                 is_chosen;
	logic                 in_sweep;

	assign page_ext = PX'(page_number);
	assign match    = head_valid && (head_page == page_q);
	assign hit_now  = hit_q || match;

	// victim: first clear bit from hand onward, else wrapped, else hand
	assign all_set = !cand_lo_q;
	always_comb begin
		if (cand_hi_q) begin
			chosen = cand_hi_idx_q;
		end else if (cand_lo_q) begin
			chosen = cand_lo_idx_q;
		end else begin
			chosen = hand_q;
		end
	end

	assign is_chosen = (idx_q == chosen);

	// frames the hand passes over get their use bit cleared
	always_comb begin
		if (all_set) begin
			in_sweep = 1'b1;
		end else if (chosen >= hand_q) begin
			in_sweep = (idx_q >= hand_q) && (idx_q < chosen);
		end else begin
			in_sweep = (idx_q >= hand_q) || (idx_q < chosen);
		end
	end

	// head word, modified, goes back into the tail
	always_comb begin
		fb_page  = head_page;
		fb_valid = head_valid;
		fb_use   = head_use;
		if (state_q == ST_SEARCH) begin
			if (match && !hit_q) begin
				fb_use = 1'b1;
			end
		end else if (is_chosen) begin
			fb_page  = page_q;
			fb_valid = 1'b1;
			fb_use   = 1'b1;
		end else if (in_sweep) begin
			fb_use = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			page_q <= page_ext[PAGE_BITS-1:0];
		end
		if (state_q == ST_SEARCH) begin
			if (match && !hit_q) begin
				hit_frame_q <= idx_q;
			end
			if (!head_use && !cand_hi_q && idx_q >= hand_q) begin
				cand_hi_idx_q <= idx_q;
			end
			if (!head_use && !cand_lo_q) begin
				cand_lo_idx_q <= idx_q;
			end
		end
		if (state_q == ST_UPDATE && is_chosen) begin
			ev_valid_q <= head_valid;
			ev_page_q  <= head_valid ? head_page : '0;
			ev_frame_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			hand_q    <= '0;
			hit_q     <= 1'b0;
			cand_hi_q <= 1'b0;
			cand_lo_q <= 1'b0;
			fault_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q     <= '0;
						hit_q     <= 1'b0;
						cand_hi_q <= 1'b0;
						cand_lo_q <= 1'b0;
						// hand past a lowered count restarts at frame 0
						if (hand_q > last_idx) begin
							hand_q <= '0;
						end
					end
				end
				ST_SEARCH: begin
					idx_q <= at_last ? '0 : idx_q + FW'(1);
					if (match) begin
						hit_q <= 1'b1;
					end
					if (!head_use && idx_q >= hand_q) begin
						cand_hi_q <= 1'b1;
					end
					if (!head_use) begin
						cand_lo_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					idx_q <= at_last ? '0 : idx_q + FW'(1);
					if (at_last) begin
						hand_q <= (chosen == last_idx) ? '0 : chosen + FW'(1);
						if (fault_q != '1) begin
							fault_q <= fault_q + FAULT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [FW-1:0]        out_frame_q;
	logic                 out_ev_valid_q;
	logic [PAGE_BITS-1:0] out_ev_page_q;
	logic [FAULT_W-1:0]   out_fault_q;
	logic [FX-1:0]        frame_ext;
	logic [PX-1:0]        ev_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hit_q      <= hit_q;
			out_frame_q    <= hit_q ? hit_frame_q : ev_frame_q;
			out_ev_valid_q <= !hit_q && ev_valid_q;
			out_ev_page_q  <= hit_q ? '0 : ev_page_q;
			out_fault_q    <= fault_q;
		end
	end

	assign frame_ext = FX'(out_frame_q);
	assign ev_ext    = PX'(out_ev_page_q);

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign frame_index   = frame_ext[FRAME_PORT_W-1:0];
	assign evicted_valid = out_ev_valid_q;
	assign evicted_page  = ev_ext[PAGE_PORT_W-1:0];
	assign fault_total   = out_fault_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`CPR_ASSERT(a_fault_monotonic, fault_q >= $past(fault_q))
	`CPR_ASSERT_IMP(a_hand_in_range, state_q == ST_UPDATE, hand_q <= last_idx)
	`CPR_ASSERT_IMP(a_idx_in_range, state_q == ST_SEARCH || state_q == ST_UPDATE, idx_q <= last_idx)
	`CPR_ASSERT_IMP(a_hit_no_evict, out_valid && hit, !evicted_valid && evicted_page == '0)

endmodule
